[rtl/core/abrt_pkg.sv]
// ----------------------------------------------------------------------------
// abrt_pkg: shared types, constants and microcode for the alpha-beta tracker
// Control word layout, datapath opcodes, register indexes and the
// sequencer program.
// ----------------------------------------------------------------------------
package abrt_pkg;

    localparam int PC_W      = 4;
    localparam int DIV_STEPS = 21;                 // 42 dividend bits, 2 per step
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 3;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RANGE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SPEED = 3'd4;

    // register reset values
    localparam logic [16:0]        RST_RANGE_GAIN    = 17'd13107;
    localparam logic [16:0]        RST_SPEED_GAIN    = 17'd6554;
    localparam logic [15:0]        RST_INTERVAL      = 16'd1280;
    localparam logic signed [31:0] RST_INITIAL_RANGE = 32'sd7680000;
    localparam logic signed [31:0] RST_INITIAL_SPEED = 32'sd10240;

    // program addresses
    localparam logic [PC_W-1:0] PC_START    = 4'd0;
    localparam logic [PC_W-1:0] PC_PRIME    = 4'd1;
    localparam logic [PC_W-1:0] PC_MAIN     = 4'd4;
    localparam logic [PC_W-1:0] PC_DIV_LOOP = 4'd11;
    localparam logic [PC_W-1:0] PC_LAST     = 4'd15;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_PRIME,
        OP_INNOV,
        OP_EST_R,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_EST_S,
        OP_NEXT
    } op_t;

    typedef enum logic [1:0] {
        A_INNOV,
        A_INIT_SPD,
        A_EST_SPD
    } a_sel_t;

    typedef enum logic [1:0] {
        B_RGAIN,
        B_SGAIN,
        B_IVAL
    } b_sel_t;

    typedef enum logic [1:0] {
        J_NEXT,    // fall through
        J_START,   // wait for an input beat, then branch on primed
        J_LOOP,    // repeat while the step counter is nonzero
        J_OUT      // wait for a free output slot, then jump
    } jmp_t;

    typedef struct packed {
        op_t    op;
        a_sel_t a_sel;
        b_sel_t b_sel;
    } dp_ctrl_t;

    typedef struct packed {
        dp_ctrl_t        dp;
        jmp_t            jmp;
        logic [PC_W-1:0] target;
        logic            cnt_load;
    } uword_t;

    typedef struct packed {
        logic [16:0]        range_gain;
        logic [16:0]        speed_gain;
        logic [15:0]        eff_interval;   // zero already mapped to one
        logic signed [31:0] initial_range;
        logic signed [31:0] initial_speed;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] est_range;
        logic signed [31:0] est_speed;
        logic signed [31:0] next_range;
    } res_t;

    function automatic uword_t mk(input op_t op, input a_sel_t a, input b_sel_t b,
                                  input jmp_t j, input logic [PC_W-1:0] t,
                                  input logic c);
        uword_t w;
        w.dp.op    = op;
        w.dp.a_sel = a;
        w.dp.b_sel = b;
        w.jmp      = j;
        w.target   = t;
        w.cnt_load = c;
        return w;
    endfunction

    // sequencer program
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            4'd0:  w = mk(OP_LOAD,     A_INNOV,    B_RGAIN, J_START, PC_MAIN,     1'b0);
            // priming: predicted range from initial registers
            4'd1:  w = mk(OP_MUL_LO,   A_INIT_SPD, B_IVAL,  J_NEXT,  PC_START,    1'b0);
            4'd2:  w = mk(OP_MUL_HI,   A_INIT_SPD, B_IVAL,  J_NEXT,  PC_START,    1'b0);
            4'd3:  w = mk(OP_PRIME,    A_INNOV,    B_RGAIN, J_NEXT,  PC_START,    1'b0);
            // update
            4'd4:  w = mk(OP_INNOV,    A_INNOV,    B_RGAIN, J_NEXT,  PC_START,    1'b0);
            4'd5:  w = mk(OP_MUL_LO,   A_INNOV,    B_RGAIN, J_NEXT,  PC_START,    1'b0);
            4'd6:  w = mk(OP_MUL_HI,   A_INNOV,    B_RGAIN, J_NEXT,  PC_START,    1'b0);
            4'd7:  w = mk(OP_EST_R,    A_INNOV,    B_RGAIN, J_NEXT,  PC_START,    1'b0);
            4'd8:  w = mk(OP_MUL_LO,   A_INNOV,    B_SGAIN, J_NEXT,  PC_START,    1'b0);
            4'd9:  w = mk(OP_MUL_HI,   A_INNOV,    B_SGAIN, J_NEXT,  PC_START,    1'b0);
            4'd10: w = mk(OP_DIV_INIT, A_INNOV,    B_SGAIN, J_NEXT,  PC_START,    1'b1);
            4'd11: w = mk(OP_DIV_STEP, A_INNOV,    B_IVAL,  J_LOOP,  PC_DIV_LOOP, 1'b0);
            4'd12: w = mk(OP_EST_S,    A_INNOV,    B_IVAL,  J_NEXT,  PC_START,    1'b0);
            // prediction
            4'd13: w = mk(OP_MUL_LO,   A_EST_SPD,  B_IVAL,  J_NEXT,  PC_START,    1'b0);
            4'd14: w = mk(OP_MUL_HI,   A_EST_SPD,  B_IVAL,  J_NEXT,  PC_START,    1'b0);
            4'd15: w = mk(OP_NEXT,     A_EST_SPD,  B_IVAL,  J_OUT,   PC_START,    1'b0);
            default: w = mk(OP_LOAD,   A_INNOV,    B_RGAIN, J_START, PC_MAIN,     1'b0);
        endcase
        return w;
    endfunction

endpackage

[rtl/core/alpha_beta_range_tracker_top.sv]
// ----------------------------------------------------------------------------
// alpha_beta_range_tracker_top: alpha-beta range/speed tracker
// Microcoded sequencer, configuration registers and output register around
// the tracker datapath.
// ----------------------------------------------------------------------------
// One range measurement per input beat produces one result beat carrying the
// estimated range, estimated speed, predicted next range and predicted next
// speed (1/256 m and 1/256 m/s, saturated to 32 bits). Gains are unsigned
// Q1.16 and the interval is in 1/256 s; an interval of zero acts as one. The
// first item after reset first forms the prediction from the initial range
// and speed registers. An item runs through the 16-step microcode program:
// three passes through the shared multiplier (four for the first item), each
// a low and a high half, and a restoring divider that retires two quotient
// bits per cycle. A new item is not accepted before the program returns to
// its start; it is accepted as soon as it does, even while the previous
// result still sits in the output register; the program stalls at its last
// step only if that register is still full and m_ready is low. Configuration
// writes are taken every cycle and must only be issued while the block is
// idle; initial range and speed take effect at the first item after reset only.
// ----------------------------------------------------------------------------
module alpha_beta_range_tracker_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [abrt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                         cfg_data,
    // measurement channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [31:0]                  s_measured_range,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [31:0]                  m_estimated_range,
    output logic signed [31:0]                  m_estimated_speed,
    output logic signed [31:0]                  m_next_range,
    output logic signed [31:0]                  m_next_speed
);

    // configuration registers
    logic [16:0]        range_gain_reg;
    logic [16:0]        speed_gain_reg;
    logic [15:0]        interval_reg;
    logic signed [31:0] init_range_reg;
    logic signed [31:0] init_speed_reg;
    abrt_pkg::cfg_t     cfg;

    // sequencer
    logic [abrt_pkg::PC_W-1:0]  pc_reg, pc_next;
    logic [abrt_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       primed_reg;
    abrt_pkg::uword_t           uw;
    logic                       dp_en;
    logic                       s_beat;
    logic                       out_free;

    // output register
    logic                       m_valid_reg;
    logic signed [31:0]         m_range_reg;
    logic signed [31:0]         m_speed_reg;
    logic signed [31:0]         m_next_reg;
    abrt_pkg::res_t             res;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_gain_reg <= abrt_pkg::RST_RANGE_GAIN;
            speed_gain_reg <= abrt_pkg::RST_SPEED_GAIN;
            interval_reg   <= abrt_pkg::RST_INTERVAL;
            init_range_reg <= abrt_pkg::RST_INITIAL_RANGE;
            init_speed_reg <= abrt_pkg::RST_INITIAL_SPEED;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                abrt_pkg::REG_RANGE_GAIN:    range_gain_reg <= cfg_data[16:0];
                abrt_pkg::REG_SPEED_GAIN:    speed_gain_reg <= cfg_data[16:0];
                abrt_pkg::REG_INTERVAL:      interval_reg   <= cfg_data[15:0];
                abrt_pkg::REG_INITIAL_RANGE: init_range_reg <= $signed(cfg_data);
                abrt_pkg::REG_INITIAL_SPEED: init_speed_reg <= $signed(cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.range_gain    = range_gain_reg;
        cfg.speed_gain    = speed_gain_reg;
        cfg.eff_interval  = (interval_reg == '0) ? 16'd1 : interval_reg;
        cfg.initial_range = init_range_reg;
        cfg.initial_speed = init_speed_reg;
    end

    // ---------------- sequencer ----------------
    // Current control word straight from the program table.
    assign uw       = abrt_pkg::ucode(pc_reg);
    assign s_ready  = (uw.jmp == abrt_pkg::J_START);
    assign s_beat   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Datapath advances every cycle except while waiting on a handshake.
    always_comb begin
        case (uw.jmp)
            abrt_pkg::J_START: dp_en = s_valid;
            abrt_pkg::J_OUT:   dp_en = out_free;
            default:           dp_en = 1'b1;
        endcase
    end

    always_comb begin
        pc_next  = pc_reg;
        cnt_next = cnt_reg;
        case (uw.jmp)
            abrt_pkg::J_NEXT: pc_next = pc_reg + 1'b1;
            abrt_pkg::J_START: begin
                // skip the priming steps once the prediction exists
                if (s_beat) begin
                    pc_next = primed_reg ? uw.target : pc_reg + 1'b1;
                end
            end
            abrt_pkg::J_LOOP: begin
                if (cnt_reg != '0) begin
                    pc_next  = uw.target;
                    cnt_next = cnt_reg - 1'b1;
                end else begin
                    pc_next = pc_reg + 1'b1;
                end
            end
            abrt_pkg::J_OUT: begin
                if (out_free) begin
                    pc_next = uw.target;
                end
            end
            default: pc_next = abrt_pkg::PC_START;
        endcase
        if (uw.cnt_load) begin
            cnt_next = abrt_pkg::CNT_W'(abrt_pkg::DIV_STEPS - 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg     <= abrt_pkg::PC_START;
            cnt_reg    <= '0;
            primed_reg <= 1'b0;
        end else begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
            if (dp_en && uw.dp.op == abrt_pkg::OP_PRIME) begin
                primed_reg <= 1'b1;
            end
        end
    end

    // ---------------- datapath ----------------
    abrt_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (dp_en),
        .ctrl    (uw.dp),
        .cfg     (cfg),
        .meas    (s_measured_range),
        .res     (res)
    );

    // ---------------- output register ----------------
    // Loaded on the last program step; next_speed equals the estimated speed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (uw.jmp == abrt_pkg::J_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (uw.jmp == abrt_pkg::J_OUT && out_free) begin
            m_range_reg <= res.est_range;
            m_speed_reg <= res.est_speed;
            m_next_reg  <= res.next_range;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_estimated_range = m_range_reg;
    assign m_estimated_speed = m_speed_reg;
    assign m_next_range      = m_next_reg;
    assign m_next_speed      = m_speed_reg;

`ifndef SYNTHESIS
    // first beat after reset takes the priming path
    a_prime_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && !primed_reg) |=> (pc_reg == abrt_pkg::PC_PRIME))
        else $error("unprimed item skipped priming");

    // loop counter only live inside the divider loop
    a_cnt_scope: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0) |-> (pc_reg == abrt_pkg::PC_DIV_LOOP))
        else $error("step counter live outside divider loop");

    // a result appears only right after the final program step
    a_out_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(pc_reg) == abrt_pkg::PC_LAST))
        else $error("result raised outside final step");

    // once primed, stays primed until reset
    a_primed_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        primed_reg |=> primed_reg)
        else $error("primed flag dropped");

    // finishing the last step returns the program to its start
    a_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == abrt_pkg::PC_LAST && out_free) |=> (pc_reg == abrt_pkg::PC_START))
        else $error("program did not return to start");
`endif

endmodule

[rtl/core/abrt_datapath.sv]
// ----------------------------------------------------------------------------
// abrt_datapath: arithmetic datapath of the alpha-beta tracker
// Shared low/high split multiplier, rounding/saturation, radix-4 restoring
// divider and the predicted range/speed state, one opcode per enabled cycle.
// ----------------------------------------------------------------------------
module abrt_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  abrt_pkg::dp_ctrl_t     ctrl,
    input  abrt_pkg::cfg_t         cfg,
    input  logic signed [31:0]     meas,
    output abrt_pkg::res_t         res
);

    localparam logic signed [45:0] S32_MAX = 46'sd2147483647;
    localparam logic signed [45:0] S32_MIN = -46'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [45:0] v);
        if (v > S32_MAX) begin
            return S32_MAX[31:0];
        end else if (v < S32_MIN) begin
            return S32_MIN[31:0];
        end
        return v[31:0];
    endfunction

    // round to nearest, halves away from zero: (v + half - neg) >> s
    function automatic logic signed [41:0] rnd8(input logic signed [49:0] v);
        logic [49:0] s;
        s = 50'(v) + 50'd128 - 50'(v[49]);
        return s[49:8];
    endfunction

    function automatic logic signed [33:0] rnd16(input logic signed [49:0] v);
        logic [49:0] s;
        s = 50'(v) + 50'd32768 - 50'(v[49]);
        return s[49:16];
    endfunction

    logic signed [49:0] acc_reg;
    logic signed [32:0] innov_reg;
    logic signed [31:0] pr_reg;
    logic signed [31:0] ps_reg;
    logic signed [31:0] er_reg;
    logic signed [31:0] es_reg;
    logic [15:0]        rem_reg;
    logic [41:0]        dq_reg;
    logic               neg_reg;

    logic signed [32:0] mul_a;
    logic [16:0]        mul_b;
    logic [33:0]        lo_prod;
    logic signed [33:0] hi_prod;
    logic signed [41:0] acc_rnd8;
    logic signed [33:0] acc_rnd16;
    logic [33:0]        t_mag;
    logic [16:0]        ivx;
    logic [16:0]        r1, r1s, r2, r2s;
    logic               b1, b2;
    logic signed [42:0] q_mag;
    logic signed [42:0] q_signed;
    logic signed [31:0] prime_range;
    logic signed [31:0] est_range;
    logic signed [31:0] est_speed;
    logic signed [31:0] next_range;

    // operand select
    always_comb begin
        case (ctrl.a_sel)
            abrt_pkg::A_INNOV:    mul_a = innov_reg;
            abrt_pkg::A_INIT_SPD: mul_a = 33'(cfg.initial_speed);
            abrt_pkg::A_EST_SPD:  mul_a = 33'(es_reg);
            default:              mul_a = innov_reg;
        endcase
        case (ctrl.b_sel)
            abrt_pkg::B_RGAIN: mul_b = cfg.range_gain;
            abrt_pkg::B_SGAIN: mul_b = cfg.speed_gain;
            abrt_pkg::B_IVAL:  mul_b = {1'b0, cfg.eff_interval};
            default:           mul_b = cfg.range_gain;
        endcase
    end

    // split multiply: low 17 bits unsigned, high 16 bits signed
    assign lo_prod = 34'(mul_a[16:0]) * 34'(mul_b);
    assign hi_prod = $signed(mul_a[32:17]) * $signed({1'b0, mul_b});

    assign acc_rnd8  = rnd8(acc_reg);
    assign acc_rnd16 = rnd16(acc_reg);

    assign prime_range = sat32(46'(cfg.initial_range) + 46'(acc_rnd8));
    assign est_range   = sat32(46'(pr_reg) + 46'(acc_rnd16));
    assign next_range  = sat32(46'(er_reg) + 46'(acc_rnd8));

    assign t_mag = acc_rnd16[33] ? 34'(-acc_rnd16) : 34'(acc_rnd16);

    // two restoring division steps per cycle
    always_comb begin
        ivx = {1'b0, cfg.eff_interval};
        r1  = {rem_reg, dq_reg[41]};
        b1  = (r1 >= ivx);
        r1s = b1 ? r1 - ivx : r1;
        r2  = {r1s[15:0], dq_reg[40]};
        b2  = (r2 >= ivx);
        r2s = b2 ? r2 - ivx : r2;
    end

    assign q_mag     = $signed({1'b0, dq_reg});
    assign q_signed  = neg_reg ? -q_mag : q_mag;
    assign est_speed = sat32(46'(ps_reg) + 46'(q_signed));

    // tracker state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pr_reg <= '0;
            ps_reg <= '0;
        end else if (en) begin
            case (ctrl.op)
                abrt_pkg::OP_PRIME: begin
                    pr_reg <= prime_range;
                    ps_reg <= cfg.initial_speed;
                end
                abrt_pkg::OP_NEXT: begin
                    pr_reg <= next_range;
                    ps_reg <= es_reg;
                end
                default: begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (en) begin
            case (ctrl.op)
                abrt_pkg::OP_LOAD:     innov_reg <= 33'(meas);
                abrt_pkg::OP_INNOV:    innov_reg <= innov_reg - 33'(pr_reg);
                abrt_pkg::OP_MUL_LO:   acc_reg   <= $signed(50'(lo_prod));
                abrt_pkg::OP_MUL_HI:   acc_reg   <= acc_reg + $signed({hi_prod[32:0], 17'd0});
                abrt_pkg::OP_EST_R:    er_reg    <= est_range;
                abrt_pkg::OP_DIV_INIT: begin
                    neg_reg <= acc_rnd16[33];
                    dq_reg  <= {t_mag, 8'd0};
                    rem_reg <= '0;
                end
                abrt_pkg::OP_DIV_STEP: begin
                    rem_reg <= r2s[15:0];
                    dq_reg  <= {dq_reg[39:0], b1, b2};
                end
                abrt_pkg::OP_EST_S:    es_reg    <= est_speed;
                default: begin
                end
            endcase
        end
    end

    assign res.est_range  = er_reg;
    assign res.est_speed  = es_reg;
    assign res.next_range = next_range;

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for alpha_beta_range_tracker_top
// A directed table (priming, saturation, gain and interval corners) is walked
// first. Randomized tracking phases follow, with register changes between
// them. Every result beat is checked against a bit-exact tracker kept here.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GAP_MAX       = 18;    // per-beat idle draw, both sides
    localparam int BURST_LEN     = 40;    // beats between burst/idle mode draws
    localparam int PHASES        = 12;
    localparam int PHASE_MEAS    = 95;
    localparam int HOLD_CYCLES   = 400;   // long sink stall to back up the block
    localparam int IDLE_LIMIT    = 3000;  // cycles without any beat
    localparam int SETTLE_CYCLES = 40;    // a bit over one item's latency
    localparam int SHOW_MAX      = 10;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic [31:0] GAIN_ONE = 32'd65536;
    localparam logic [31:0] GAIN_TOP = 32'h0001_FFFF;

    localparam int IDX_W = abrt_pkg::CFG_IDX_W;
    // indexes past the last register; writes there must be dropped
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = '1;

    typedef struct packed {
        logic signed [31:0] est_range;
        logic signed [31:0] est_speed;
        logic signed [31:0] next_range;
        logic signed [31:0] next_speed;
    } track_t;

    typedef enum logic {ROW_WRITE, ROW_MEAS} row_kind_t;

    // one line of the directed table: a register write or a measurement,
    // the latter optionally with a hand-computed result
    typedef struct {
        row_kind_t        kind;
        logic [IDX_W-1:0] idx;
        logic [31:0]      data;
        bit               known;
        track_t           want;
    } row_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index;
    logic [31:0]        cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_measured_range;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_estimated_range;
    logic signed [31:0] m_estimated_speed;
    logic signed [31:0] m_next_range;
    logic signed [31:0] m_next_speed;

    alpha_beta_range_tracker_top uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_measured_range  (s_measured_range),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_estimated_range (m_estimated_range),
        .m_estimated_speed (m_estimated_speed),
        .m_next_range      (m_next_range),
        .m_next_speed      (m_next_speed)
    );

    // ------------------------------------------------------------------
    // Tracker model: register shadows and filter state
    // ------------------------------------------------------------------
    logic [16:0]        alpha_q16   = abrt_pkg::RST_RANGE_GAIN;
    logic [16:0]        beta_q16    = abrt_pkg::RST_SPEED_GAIN;
    logic [15:0]        interval    = abrt_pkg::RST_INTERVAL;
    logic signed [31:0] start_range = abrt_pkg::RST_INITIAL_RANGE;
    logic signed [31:0] start_speed = abrt_pkg::RST_INITIAL_SPEED;

    logic signed [31:0] trk_range  = '0;
    logic signed [31:0] trk_speed  = '0;
    bit                 trk_primed = 1'b0;

    track_t pending_tracks[$];    // expected result beats, oldest first

    int  send_beats      = 0;
    int  results_checked = 0;
    int  mismatches      = 0;
    int  writes_done     = 0;
    int  holds_done      = 0;
    int  idle_cycles     = 0;
    bit  send_burst      = 1'b0;
    bit  hold_req        = 1'b0;  // stimulus asks the sink for a long stall

    function automatic longint sat32(input longint v);
        if (v > longint'(S32_MAX)) return longint'(S32_MAX);
        if (v < longint'(S32_MIN)) return longint'(S32_MIN);
        return v;
    endfunction

    // divide by 2^sh, nearest, ties away from zero
    function automatic longint round_shift(input longint v, input int unsigned sh);
        longint mag;
        longint r;
        mag = (v < 0) ? -v : v;
        r = (mag + (longint'(1) << (sh - 1))) >> sh;
        return (v < 0) ? -r : r;
    endfunction

    function automatic void apply_write(input logic [IDX_W-1:0] idx, input logic [31:0] data);
        case (idx)
            abrt_pkg::REG_RANGE_GAIN:    alpha_q16   = data[16:0];
            abrt_pkg::REG_SPEED_GAIN:    beta_q16    = data[16:0];
            abrt_pkg::REG_INTERVAL:      interval    = data[15:0];
            abrt_pkg::REG_INITIAL_RANGE: start_range = data;
            abrt_pkg::REG_INITIAL_SPEED: start_speed = data;
            default: ;
        endcase
    endfunction

    // one filter update; advances the model state
    function automatic track_t track_step(input logic signed [31:0] meas);
        track_t res;
        longint dt;
        longint innov;
        longint est_r;
        longint est_s;
        longint blend;
        dt = (interval == 0) ? 1 : longint'(interval);
        if (!trk_primed) begin
            trk_range  = 32'(sat32(longint'(start_range)
                                   + round_shift(longint'(start_speed) * dt, 8)));
            trk_speed  = start_speed;
            trk_primed = 1'b1;
        end
        innov = longint'(meas) - longint'(trk_range);
        est_r = sat32(longint'(trk_range) + round_shift(innov * longint'(alpha_q16), 16));
        blend = round_shift(innov * longint'(beta_q16), 16);
        est_s = sat32(longint'(trk_speed) + (blend * 256) / dt);
        res.est_range  = 32'(est_r);
        res.est_speed  = 32'(est_s);
        res.next_range = 32'(sat32(est_r + round_shift(est_s * dt, 8)));
        res.next_speed = 32'(est_s);
        trk_range = res.next_range;
        trk_speed = res.est_speed;
        return res;
    endfunction

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return GAIN_ONE;
            2:       return GAIN_TOP;
            3:       return $urandom;             // upper bits must be ignored
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    function automatic row_t reg_row(input logic [IDX_W-1:0] idx, input logic [31:0] data);
        row_t r;
        r.kind  = ROW_WRITE;
        r.idx   = idx;
        r.data  = data;
        r.known = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic row_t meas_row(input logic signed [31:0] meas, input bit known,
                                      input track_t want);
        row_t r;
        r.kind  = ROW_MEAS;
        r.idx   = '0;
        r.data  = meas;
        r.known = known;
        r.want  = want;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Inputs move on the falling edge, handshakes are seen on
    // the rising edge.
    // ------------------------------------------------------------------
    task automatic send_measurement(input logic signed [31:0] meas, input bit known,
                                    input track_t want);
        int unsigned gap;
        track_t      model;
        if (send_beats % BURST_LEN == 0) send_burst = ($urandom_range(0, 3) == 0);
        gap = send_burst ? 0 : $urandom_range(0, GAP_MAX);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_measured_range <= meas;
        do @(posedge aclk); while (!s_ready);
        // model always advances; a typed row overrides only the expectation
        model = track_step(meas);
        pending_tracks.push_back(known ? want : model);
        send_beats++;
    endtask

    // stop offering and wait for every outstanding result beat
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_tracks.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_write(idx, data);
        writes_done++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Result sink: random ready gaps, burst stretches with none, and a
    // long stall on request so the block fills and pushes back on input.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int unsigned gap;
        int unsigned beats;
        bit          burst;
        beats   = 0;
        burst   = 1'b0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (beats % BURST_LEN == 0) burst = ($urandom_range(0, 3) == 0);
            gap = burst ? 0 : $urandom_range(0, GAP_MAX);
            if (hold_req) begin
                gap      = HOLD_CYCLES;
                hold_req = 1'b0;
                holds_done++;
            end
            @(negedge aclk);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            beats++;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each result beat against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        track_t got;
        track_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_estimated_range, m_estimated_speed, m_next_range, m_next_speed};
            if (pending_tracks.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("%0t: result beat with nothing expected: %0d %0d %0d %0d",
                             $realtime, got.est_range, got.est_speed, got.next_range,
                             got.next_speed);
            end else begin
                want = pending_tracks.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display("%0t: beat %0d exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 $realtime, results_checked, want.est_range,
                                 want.est_speed, want.next_range, want.next_speed,
                                 got.est_range, got.est_speed, got.next_range,
                                 got.next_speed);
                end
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any beat on any channel counts as progress
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, pending_tracks.size());
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        row_t               rows[$];
        logic signed [31:0] meas;
        logic [31:0]        dt_word;
        longint             noise;
        int unsigned        noise_bits;

        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_measured_range = '0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;

        // Directed table. Known rows were worked by hand; the rest use the
        // model. Gain one with interval 256 (one second) makes the speed
        // term pass straight through, so saturation is easy to read off.
        // first item primes from the reset registers: 7680000 + 10240*5 s
        rows.push_back(meas_row(32'sd7731200, 1'b1,
            '{32'sd7731200, 32'sd10240, 32'sd7782400, 32'sd10240}));
        // initial registers changed after priming: no effect
        rows.push_back(reg_row(abrt_pkg::REG_INITIAL_RANGE, S32_MIN));
        rows.push_back(reg_row(abrt_pkg::REG_INITIAL_SPEED, S32_MAX));
        rows.push_back(meas_row(32'sd7782400, 1'b1,
            '{32'sd7782400, 32'sd10240, 32'sd7833600, 32'sd10240}));
        rows.push_back(reg_row(abrt_pkg::REG_RANGE_GAIN, GAIN_ONE));
        rows.push_back(reg_row(abrt_pkg::REG_SPEED_GAIN, 32'd0));
        rows.push_back(reg_row(abrt_pkg::REG_INTERVAL, 32'd256));
        // next range clamps high, then a full-scale swing down
        rows.push_back(meas_row(S32_MAX, 1'b1, '{S32_MAX, 32'sd10240, S32_MAX, 32'sd10240}));
        rows.push_back(meas_row(S32_MIN, 1'b1,
            '{S32_MIN, 32'sd10240, -32'sd2147473408, 32'sd10240}));
        rows.push_back(meas_row(32'sd0, 1'b1, '{32'sd0, 32'sd10240, 32'sd10240, 32'sd10240}));
        // zero interval acts as one; speed saturates on full-scale steps
        rows.push_back(reg_row(abrt_pkg::REG_SPEED_GAIN, GAIN_ONE));
        rows.push_back(reg_row(abrt_pkg::REG_INTERVAL, 32'd0));
        rows.push_back(meas_row(S32_MAX, 1'b0, '0));
        rows.push_back(meas_row(S32_MIN, 1'b0, '0));
        // gains above one, no clamping
        rows.push_back(reg_row(abrt_pkg::REG_RANGE_GAIN, GAIN_TOP));
        rows.push_back(reg_row(abrt_pkg::REG_SPEED_GAIN, GAIN_TOP));
        rows.push_back(meas_row(-32'sd1, 1'b0, '0));
        rows.push_back(meas_row(32'sd1, 1'b0, '0));
        rows.push_back(reg_row(abrt_pkg::REG_INTERVAL, 32'd65535));
        rows.push_back(meas_row(32'sh5555_5555, 1'b0, '0));
        rows.push_back(meas_row(32'shAAAA_AAAA, 1'b0, '0));
        rows.push_back(reg_row(abrt_pkg::REG_RANGE_GAIN, 32'd0));
        rows.push_back(meas_row(S32_MAX, 1'b0, '0));
        // write past the register file must be dropped
        rows.push_back(reg_row(REG_SPARE_HI, 32'hFFFF_FFFF));
        rows.push_back(meas_row(S32_MIN, 1'b0, '0));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_WRITE) begin
                drain_results();
                write_register(rows[i].idx, rows[i].data);
            end else begin
                send_measurement(rows[i].data, rows[i].known, rows[i].want);
            end
        end

        // Random phases: new gains and interval each time, then mostly
        // measurements near the current prediction (a target being
        // tracked) with some full-range noise and extremes mixed in.
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            write_register(abrt_pkg::REG_RANGE_GAIN, rand_gain());
            write_register(abrt_pkg::REG_SPEED_GAIN, rand_gain());
            case ($urandom_range(0, 5))
                0:       dt_word = 32'd0;
                1:       dt_word = 32'd1;
                2:       dt_word = 32'd65535;
                3:       dt_word = $urandom;
                default: dt_word = $urandom_range(64, 2048);
            endcase
            write_register(abrt_pkg::REG_INTERVAL, dt_word);
            if ($urandom_range(0, 2) == 0)
                write_register($urandom_range(0, 1) ? abrt_pkg::REG_INITIAL_RANGE
                                                    : abrt_pkg::REG_INITIAL_SPEED, $urandom);
            if ($urandom_range(0, 3) == 0)
                write_register(IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
            if (p % 5 == 3) hold_req = 1'b1;
            noise_bits = $urandom_range(2, 24);

            for (int k = 0; k < PHASE_MEAS; k++) begin
                case ($urandom_range(0, 9))
                    0: meas = $urandom;
                    1: begin
                        case ($urandom_range(0, 3))
                            0:       meas = S32_MAX;
                            1:       meas = S32_MIN;
                            2:       meas = 32'sd0;
                            default: meas = -32'sd1;
                        endcase
                    end
                    default: begin
                        noise = longint'($urandom) % (longint'(1) << noise_bits);
                        if ($urandom_range(0, 1) == 1) noise = -noise;
                        meas = 32'(sat32(longint'(trk_range) + noise));
                    end
                endcase
                send_measurement(meas, 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d measurements over %0d random phases, %0d register writes,",
                 send_beats, PHASES, writes_done);
        $display("%0d long output stalls; %0d result beats checked, %0d mismatches.",
                 holds_done, results_checked, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/abrt_pkg.sv
rtl/core/abrt_datapath.sv
rtl/core/alpha_beta_range_tracker_top.sv
verif/tb.sv
